@@ rtl/apv_pkg.sv @@
// Shared types, constants and SHA-256 helpers for the packet verifier.
package apv_pkg;

    localparam int MAX_PAYLOAD = 1024;
    localparam int HEAD_LEN    = 14;
    localparam int TAG_LEN     = 8;
    localparam int CNT_W       = $clog2(HEAD_LEN + MAX_PAYLOAD + 1);
    localparam int PLEN_W      = 11;

    localparam logic [0:0] CFG_TOKEN_HIGH = 1'b0;
    localparam logic [0:0] CFG_TOKEN_LOW  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_LONG     = 2'd3;

    // queue entry opcodes
    typedef enum logic [1:0] {
        OP_TOKEN = 2'd0,   // hash the 16-byte token (packet start)
        OP_BYTE  = 2'd1,   // hash one byte, optionally forward as payload
        OP_FINAL = 2'd2    // verdict
    } apv_op_t;

    typedef struct packed {
        apv_op_t                 op;
        logic [7:0]              data;
        logic                    fwd;
        logic                    need_hash;
        logic [1:0]              status;
        logic [31:0]             serial;
        logic [15:0]             header;
        logic [PLEN_W-1:0]       plen;
        logic [63:0]             tag;
        logic [CNT_W-1:0]        msg_len;
    } apv_cmd_t;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/apv_front.sv @@
// Front end: parses packet bytes, tracks counts and issues hash commands.
module apv_front
    import apv_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [7:0]     s_packet_byte,
    input  logic           s_is_final,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           cmd_valid,
    output apv_cmd_t       cmd,
    input  logic           cmd_ready
);

    typedef enum logic [1:0] {F_IDLE, F_START, F_BYTE, F_FINAL} fstate_t;

    fstate_t           state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [63:0]       tag_reg;
    logic [31:0]       serial_reg;
    logic [15:0]       header_reg;
    logic              ovf_reg;
    logic [7:0]        byte_reg;
    logic              fin_reg;
    logic              fwd_reg;

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(HEAD_LEN + MAX_PAYLOAD);

    logic [CNT_W-1:0] plen_full;
    logic             short_pkt;

    assign s_ready   = (state_reg == F_IDLE);
    assign short_pkt = cnt_reg < CNT_W'(HEAD_LEN);
    assign plen_full = short_pkt ? '0 : cnt_reg - CNT_W'(HEAD_LEN);

    always_comb begin
        cmd           = '0;
        cmd.data      = byte_reg;
        cmd.fwd       = fwd_reg;
        cmd.serial    = serial_reg;
        cmd.header    = header_reg;
        cmd.plen      = PLEN_W'(plen_full);
        cmd.tag       = tag_reg;
        cmd.msg_len   = cnt_reg + CNT_W'(16 - TAG_LEN);
        cmd.need_hash = !short_pkt && !ovf_reg;
        cmd.status    = short_pkt ? ST_SHORT : (ovf_reg ? ST_LONG : ST_OK);
        unique case (state_reg)
            F_START: cmd.op = OP_TOKEN;
            F_BYTE:  cmd.op = OP_BYTE;
            default: cmd.op = OP_FINAL;
        endcase
        cmd_valid = (state_reg != F_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            cnt_reg    <= '0;
            tag_reg    <= '0;
            serial_reg <= '0;
            header_reg <= '0;
            ovf_reg    <= 1'b0;
            fin_reg    <= 1'b0;
            fwd_reg    <= 1'b0;
            byte_reg   <= '0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        byte_reg <= s_packet_byte;
                        fin_reg  <= s_is_final;
                        fwd_reg  <= 1'b0;
                        if (cnt_reg < CNT_W'(TAG_LEN)) begin
                            tag_reg <= {tag_reg[55:0], s_packet_byte};
                            cnt_reg <= cnt_reg + 1'b1;
                        end else if (cnt_reg < CNT_W'(12)) begin
                            serial_reg <= {serial_reg[23:0], s_packet_byte};
                            cnt_reg    <= cnt_reg + 1'b1;
                        end else if (cnt_reg < CNT_W'(HEAD_LEN)) begin
                            header_reg <= {header_reg[7:0], s_packet_byte};
                            cnt_reg    <= cnt_reg + 1'b1;
                        end else if (cnt_reg < LIMIT) begin
                            fwd_reg  <= 1'b1;
                            cnt_reg  <= cnt_reg + 1'b1;
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (cnt_reg == '0) begin
                            state_reg <= F_START;
                        end else if (cnt_reg < LIMIT && cnt_reg >= CNT_W'(TAG_LEN)) begin
                            state_reg <= F_BYTE;
                        end else if (s_is_final) begin
                            state_reg <= F_FINAL;
                        end
                    end
                end
                F_START: begin
                    if (cmd_ready) begin
                        state_reg <= fin_reg ? F_FINAL : F_IDLE;
                    end
                end
                F_BYTE: begin
                    if (cmd_ready) begin
                        state_reg <= fin_reg ? F_FINAL : F_IDLE;
                    end
                end
                F_FINAL: begin
                    if (cmd_ready) begin
                        state_reg  <= F_IDLE;
                        cnt_reg    <= '0;
                        tag_reg    <= '0;
                        serial_reg <= '0;
                        header_reg <= '0;
                        ovf_reg    <= 1'b0;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LIMIT) else $error("byte count past limit");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("command changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd_valid) else $error("ready while command pending");
`endif

endmodule

@@ rtl/apv_queue.sv @@
// Two-entry command queue between front end and hash engine.
module apv_queue
    import apv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  apv_cmd_t in_cmd,
    output logic     out_valid,
    input  logic     out_ready,
    output apv_cmd_t out_cmd
);

    apv_cmd_t  mem_reg [2];
    logic      wr_reg;
    logic      rd_reg;
    logic [1:0] cnt_reg;

    logic push, pop;
    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd   = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("queue overflow");
    a_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wr_reg == rd_reg)
        else $error("queue pointers out of step");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count wrong");
`endif

endmodule

@@ rtl/apv_back.sv @@
// Back end: SHA-256 engine, one round per cycle, and result output.
module apv_back
    import apv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] token_high,
    input  logic [63:0] token_low,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  apv_cmd_t    cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [1:0]  m_status,
    output logic [31:0] m_serial,
    output logic [3:0]  m_flag_bits,
    output logic [11:0] m_sequence_res,
    output logic [10:0] m_payload_length,
    output logic        m_run_end
);

    typedef enum logic [2:0] {
        B_IDLE, B_TOKEN, B_PUT, B_ROUND, B_ADD, B_PAD, B_OUT
    } bstate_t;

    bstate_t     state_reg;
    logic [31:0] h_reg  [8];
    logic [31:0] v_reg  [8];
    logic [31:0] w_reg  [16];
    logic [5:0]  pos_reg;
    logic [5:0]  rnd_reg;
    logic [3:0]  tok_reg;
    logic [7:0]  byte_reg;
    logic        fwd_reg;
    logic [3:0]  pad_reg;
    logic        padding_reg;
    apv_cmd_t    cur_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic [1:0]  out_status_reg;
    logic [31:0] out_serial_reg;
    logic [15:0] out_header_reg;
    logic [10:0] out_plen_reg;

    logic [31:0] t1, t2, s0, s1, wnew;
    logic [63:0] fold;
    logic [127:0] token;
    logic [63:0]  bits;
    logic [31:0]  put_word;

    assign token = {token_high, token_low};
    assign bits  = {50'd0, cur_reg.msg_len, 3'd0};

    always_comb begin
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + RK[rnd_reg] + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        fold = {h_reg[0], h_reg[1]} ^ {h_reg[2], h_reg[3]}
             ^ {h_reg[4], h_reg[5]} ^ {h_reg[6], h_reg[7]};
        put_word = w_reg[pos_reg[5:2]];
        unique case (pos_reg[1:0])
            2'd0: put_word = {byte_reg, 24'd0};
            2'd1: put_word[23:16] = byte_reg;
            2'd2: put_word[15:8]  = byte_reg;
            default: put_word[7:0] = byte_reg;
        endcase
    end

    assign cmd_ready = (state_reg == B_IDLE) && !out_valid_reg;
    assign m_valid          = out_valid_reg;
    assign m_kind           = out_kind_reg;
    assign m_payload_byte   = out_byte_reg;
    assign m_status         = out_status_reg;
    assign m_serial         = out_serial_reg;
    assign m_flag_bits      = out_header_reg[15:12];
    assign m_sequence_res   = out_header_reg[11:0];
    assign m_payload_length = out_plen_reg;
    assign m_run_end        = out_kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            rnd_reg       <= '0;
            tok_reg       <= '0;
            pad_reg       <= '0;
            padding_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            for (int i = 0; i < 8; i++) h_reg[i] <= IV[i];
        end else begin
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE: begin
                    if (cmd_valid && !out_valid_reg) begin
                        cur_reg  <= cmd;
                        fwd_reg  <= cmd.fwd;
                        unique case (cmd.op)
                            OP_TOKEN: begin
                                for (int i = 0; i < 8; i++) h_reg[i] <= IV[i];
                                byte_reg  <= token[127:120];
                                pos_reg   <= '0;
                                tok_reg   <= '0;
                                state_reg <= B_TOKEN;
                            end
                            OP_BYTE: begin
                                byte_reg  <= cmd.data;
                                state_reg <= B_PUT;
                            end
                            default: begin
                                if (cmd.need_hash) begin
                                    padding_reg <= 1'b1;
                                    byte_reg    <= 8'h80;
                                    pad_reg     <= '0;
                                    state_reg   <= B_PUT;
                                end else begin
                                    state_reg <= B_OUT;
                                end
                            end
                        endcase
                    end
                end
                B_TOKEN: begin
                    w_reg[pos_reg[5:2]] <= put_word;
                    pos_reg <= pos_reg + 1'b1;
                    tok_reg <= tok_reg + 1'b1;
                    byte_reg <= token[8'(7'd127 - {tok_reg + 4'd1, 3'd0}) -: 8];
                    if (tok_reg == 4'd15) state_reg <= B_IDLE;
                end
                B_PUT: begin
                    w_reg[pos_reg[5:2]] <= put_word;
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == 6'd63) begin
                        for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        rnd_reg   <= '0;
                        state_reg <= B_ROUND;
                    end else begin
                        state_reg <= B_PAD;
                    end
                end
                B_ROUND: begin
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wnew;
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63) state_reg <= B_ADD;
                end
                B_ADD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    state_reg <= B_PAD;
                end
                B_PAD: begin
                    // decides what follows a stored byte
                    if (!padding_reg) begin
                        if (fwd_reg) begin
                            out_valid_reg  <= 1'b1;
                            out_kind_reg   <= 1'b0;
                            out_byte_reg   <= byte_reg;
                            out_status_reg <= '0;
                            out_serial_reg <= '0;
                            out_header_reg <= '0;
                            out_plen_reg   <= '0;
                        end
                        state_reg <= B_IDLE;
                    end else if (pad_reg == 4'd8) begin
                        padding_reg <= 1'b0;
                        state_reg   <= B_OUT;
                    end else if (pos_reg == 6'd56 || pad_reg != 4'd0) begin
                        byte_reg  <= bits[8'(7'd63 - {pad_reg, 3'd0}) -: 8];
                        pad_reg   <= pad_reg + 1'b1;
                        state_reg <= B_PUT;
                    end else begin
                        byte_reg  <= 8'h00;
                        state_reg <= B_PUT;
                    end
                end
                B_OUT: begin
                    if (!out_valid_reg) begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= 1'b1;
                        out_byte_reg   <= '0;
                        out_status_reg <= !cur_reg.need_hash ? cur_reg.status
                                        : (fold == cur_reg.tag ? ST_OK : ST_MISMATCH);
                        out_serial_reg <= cur_reg.serial;
                        out_header_reg <= cur_reg.header;
                        out_plen_reg   <= cur_reg.plen;
                        state_reg      <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_ROUND && rnd_reg == 6'd63 |=> state_reg == B_ADD)
        else $error("round count wrong");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_ready |-> state_reg == B_IDLE) else $error("ready while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped");
`endif

endmodule

@@ rtl/auth_packet_verifier_core.sv @@
// Top level of the authenticated packet verifier.
// Path: a payload byte passes the front end, the queue and the back end's B_PUT and
// B_PAD states before it shows on m_valid; a byte that fills a 64-byte block first
// runs the 64 rounds, one per cycle, and the sum. Verdict: padding of 9 to 72 bytes,
// each through B_PUT and B_PAD, plus one or two compressions. Flow: the back end takes
// a new command only when idle with no result pending; input stalls once the queue fills.
// Reset: synchronous active-low aresetn clears control state and tokens.
module auth_packet_verifier_core
    import apv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_packet_byte,
    input  logic        s_is_final,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [1:0]  m_status,
    output logic [31:0] m_serial,
    output logic [3:0]  m_flag_bits,
    output logic [11:0] m_sequence_res,
    output logic [10:0] m_payload_length,
    output logic        m_run_end
);

    logic [63:0] token_high_reg, token_low_reg;
    logic        f_valid, f_ready, q_valid, q_ready;
    apv_cmd_t    f_cmd, q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_high_reg <= '0;
            token_low_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TOKEN_HIGH: token_high_reg <= cfg_data;
                default:        token_low_reg  <= cfg_data;
            endcase
        end
    end

    apv_front u_front (
        .aclk, .aresetn, .s_packet_byte, .s_is_final, .s_valid, .s_ready,
        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
    );

    apv_queue u_queue (
        .aclk, .aresetn, .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    apv_back u_back (
        .aclk, .aresetn, .token_high(token_high_reg), .token_low(token_low_reg),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .m_valid, .m_ready, .m_kind, .m_payload_byte, .m_status, .m_serial,
        .m_flag_bits, .m_sequence_res, .m_payload_length, .m_run_end
    );

endmodule

@@ verif/apv_tb_pkg.sv @@
// Verification helpers: result record and SHA-256 tag fold for the packet verifier.
`timescale 1ns / 1ps
package apv_tb_pkg;

    typedef bit [7:0] octets_t[$];

    localparam bit KIND_PAYLOAD = 1'b0;
    localparam bit KIND_VERDICT = 1'b1;

    typedef struct packed {
        bit        kind;
        bit [7:0]  payload_byte;
        bit [1:0]  status;
        bit [31:0] serial;
        bit [3:0]  flag_bits;
        bit [11:0] sequence_res;
        bit [10:0] payload_length;
        bit        run_end;
    } apv_result_t;

    function automatic bit [31:0] ror32(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // SHA-256 over token (16 bytes) followed by body, digest folded to 64 bits
    function automatic bit [63:0] tag_fold(bit [63:0] tok_hi, bit [63:0] tok_lo,
                                           octets_t body);
        bit [31:0] kc [64];
        bit [31:0] h [8];
        bit [31:0] v [8];
        bit [31:0] w [64];
        bit [31:0] s0, s1, t1, t2;
        bit [7:0]  m [$];
        bit [63:0] nbits;
        int        blk, i;
        kc = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
        };
        h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
              32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
        for (i = 7; i >= 0; i--) m.push_back(tok_hi[i*8 +: 8]);
        for (i = 7; i >= 0; i--) m.push_back(tok_lo[i*8 +: 8]);
        foreach (body[j]) m.push_back(body[j]);
        nbits = 64'(m.size()) * 8;
        m.push_back(8'h80);
        while ((m.size() % 64) != 56) m.push_back(8'h00);
        for (i = 7; i >= 0; i--) m.push_back(nbits[i*8 +: 8]);
        for (blk = 0; blk < m.size() / 64; blk++) begin
            for (i = 0; i < 16; i++)
                w[i] = {m[blk*64+4*i], m[blk*64+4*i+1], m[blk*64+4*i+2], m[blk*64+4*i+3]};
            for (i = 16; i < 64; i++) begin
                s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            v = h;
            for (i = 0; i < 64; i++) begin
                t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc[i] + w[i];
                t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (i = 0; i < 8; i++) h[i] = h[i] + v[i];
        end
        return {h[0], h[1]} ^ {h[2], h[3]} ^ {h[4], h[5]} ^ {h[6], h[7]};
    endfunction

endpackage

@@ verif/apv_checker.sv @@
// Checker: tracks packets on the input channel, predicts results and compares them.
`timescale 1ns / 1ps
module apv_checker
    import apv_pkg::*;
    import apv_tb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_packet_byte,
    input  logic        s_is_final,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_kind,
    input  logic [7:0]  m_payload_byte,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_serial,
    input  logic [3:0]  m_flag_bits,
    input  logic [11:0] m_sequence_res,
    input  logic [10:0] m_payload_length,
    input  logic        m_run_end,
    output int          fail_count,
    output int          pending
);

    localparam int BYTE_LIMIT = HEAD_LEN + MAX_PAYLOAD;

    bit [63:0]   tok_hi, tok_lo, pkt_tok_hi, pkt_tok_lo;
    bit [63:0]   rx_tag;
    bit [31:0]   rx_serial;
    bit [15:0]   rx_header;
    bit          overflow;
    int          byte_cnt;
    octets_t     hashed;
    apv_result_t expected_q[$];

    initial fail_count = 0;
    assign pending = expected_q.size();

    task automatic predict_item(bit [7:0] b, bit fin);
        apv_result_t r;
        if (byte_cnt == 0) begin
            pkt_tok_hi = tok_hi;
            pkt_tok_lo = tok_lo;
            rx_tag = '0; rx_serial = '0; rx_header = '0; overflow = 0;
            hashed.delete();
        end
        if (byte_cnt < TAG_LEN) begin
            rx_tag = {rx_tag[55:0], b};
            byte_cnt++;
        end else if (byte_cnt < 12) begin
            rx_serial = {rx_serial[23:0], b};
            hashed.push_back(b);
            byte_cnt++;
        end else if (byte_cnt < HEAD_LEN) begin
            rx_header = {rx_header[7:0], b};
            hashed.push_back(b);
            byte_cnt++;
        end else if (byte_cnt < BYTE_LIMIT) begin
            hashed.push_back(b);
            byte_cnt++;
            r = '0;
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            expected_q.push_back(r);
        end else begin
            overflow = 1;
        end
        if (fin) begin
            r = '0;
            r.kind = KIND_VERDICT;
            if (byte_cnt < HEAD_LEN)
                r.status = ST_SHORT;
            else if (overflow)
                r.status = ST_LONG;
            else if (tag_fold(pkt_tok_hi, pkt_tok_lo, hashed) == rx_tag)
                r.status = ST_OK;
            else
                r.status = ST_MISMATCH;
            r.serial = rx_serial;
            r.flag_bits = rx_header[15:12];
            r.sequence_res = rx_header[11:0];
            r.payload_length = byte_cnt > HEAD_LEN ? 11'(byte_cnt - HEAD_LEN) : '0;
            r.run_end = 1;
            expected_q.push_back(r);
            byte_cnt = 0;
        end
    endtask

    always @(posedge aclk) begin
        apv_result_t act, exp_r;
        if (!aresetn) begin
            tok_hi = '0;
            tok_lo = '0;
            byte_cnt = 0;
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_TOKEN_HIGH) tok_hi = cfg_data;
                else tok_lo = cfg_data;
            end
            if (m_valid && m_ready) begin
                act = {m_kind, m_payload_byte, m_status, m_serial, m_flag_bits,
                       m_sequence_res, m_payload_length, m_run_end};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, act);
                    fail_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (act !== exp_r) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, act);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_item(s_packet_byte, s_is_final);
        end
    end

endmodule

@@ verif/testbench.sv @@
// Testbench top: clock, reset, packet stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;
    import apv_pkg::*;
    import apv_tb_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [0:0]  cfg_index = CFG_TOKEN_HIGH;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_packet_byte = '0;
    logic        s_is_final = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_kind;
    logic [7:0]  m_payload_byte;
    logic [1:0]  m_status;
    logic [31:0] m_serial;
    logic [3:0]  m_flag_bits;
    logic [11:0] m_sequence_res;
    logic [10:0] m_payload_length;
    logic        m_run_end;
    int          fail_count, pending;

    bit [63:0] tok_hi, tok_lo;
    bit        idle_on = 1;
    bit        hold_long = 0;
    int        items = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    auth_packet_verifier_core dut (.*);
    apv_checker chk (.*);

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // output side: random stalls, plus one long hold on request
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_long) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                hold_long = 0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_byte(bit [7:0] b, bit fin);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1;
        s_packet_byte <= b;
        s_is_final <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items++;
    endtask

    // fill: 0 random, 1 all zero, 2 all ones
    task automatic send_packet(int len, bit good, int fill);
        octets_t   pkt, body;
        bit [63:0] t;
        int        i;
        for (i = 0; i < len; i++) begin
            case (fill)
                1: pkt.push_back(8'h00);
                2: pkt.push_back(8'hff);
                default: begin
                    case ($urandom_range(0, 9))
                        0: pkt.push_back(8'h00);
                        1: pkt.push_back(8'hff);
                        default: pkt.push_back(8'($urandom()));
                    endcase
                end
            endcase
        end
        if (good && len >= HEAD_LEN) begin
            for (i = TAG_LEN; i < len && i < HEAD_LEN + MAX_PAYLOAD; i++)
                body.push_back(pkt[i]);
            t = tag_fold(tok_hi, tok_lo, body);
            for (i = 0; i < TAG_LEN; i++) pkt[i] = t[63 - 8*i -: 8];
        end
        for (i = 0; i < len; i++) send_byte(pkt[i], i == len - 1);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    task automatic write_tokens(bit [63:0] hi, bit [63:0] lo);
        tok_hi = hi;
        tok_lo = lo;
        cfg_we <= 1;
        cfg_index <= CFG_TOKEN_HIGH;
        cfg_data <= hi;
        @(posedge aclk);
        cfg_index <= CFG_TOKEN_LOW;
        cfg_data <= lo;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic random_packet();
        int len;
        case ($urandom_range(0, 9))
            0: len = $urandom_range(1, 13);
            1: len = $urandom_range(14, 15);
            default: len = $urandom_range(16, 90);
        endcase
        send_packet(len, $urandom_range(0, 9) < 7, 0);
    endtask

    initial begin
        tok_hi = '0;
        tok_lo = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset tokens, short packets, exact head, one- and two-byte payloads
        send_packet(1, 0, 0);
        send_packet(8, 0, 2);
        send_packet(13, 0, 0);
        send_packet(14, 1, 0);
        send_packet(15, 1, 1);
        drain();
        write_tokens('1, '1);
        send_packet(15, 0, 2);
        send_packet(16, 1, 2);
        drain();
        write_tokens(64'($urandom()) << 32 | $urandom(), 64'($urandom()) << 32 | $urandom());
        send_packet(20, 1, 0);
        send_packet(20, 0, 0);
        drain();

        // long output stall while input is still offered
        hold_long = 1;
        send_packet(120, 1, 0);
        drain();

        // packet spanning several hash blocks
        send_packet(130, 1, 0);
        drain();
        write_tokens('0, '1);

        while (items < 550) begin
            if (items > 500) idle_on = 0;
            random_packet();
            if ($urandom_range(0, 11) == 0) begin
                drain();
                case ($urandom_range(0, 3))
                    0: write_tokens('0, '0);
                    1: write_tokens('1, '1);
                    default: write_tokens(64'($urandom()) << 32 | $urandom(),
                                          64'($urandom()) << 32 | $urandom());
                endcase
            end
        end
        s_valid <= 0;
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
